// File: hdl/lcabl_pkg.sv
`default_nettype none

package lcabl_pkg;

  localparam int NODE_W = 10;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_QUERY  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_REFUSED = 2'd2
  } status_t;

  typedef struct packed {
    func_t func;
    node_t node_a;
    node_t node_b;
  } in_item_t;

  typedef struct packed {
    node_t   ancestor;
    status_t status;
  } out_item_t;

  // Node number names a real table row: nonzero and below the node count
  function automatic logic node_ok(input node_t n, input int unsigned nodes);
    return (n != '0) && (32'(n) < nodes);
  endfunction

endpackage

`default_nettype wire

// File: hdl/lcabl_depth_store.sv
`default_nettype none

module lcabl_depth_store
  import lcabl_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire node_t             rd_node,
  output      logic [LEVELS-1:0] rd_data,
  input  wire logic              wr_en,
  input  wire node_t             wr_node,
  input  wire logic [LEVELS-1:0] wr_data,
  output      logic              busy
);

  localparam int NW = $clog2(NODES);

  logic [LEVELS-1:0] mem [NODES];
  logic [NW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [LEVELS-1:0] rd_q_r;
  logic              rd_ok_r;
  logic              rd_ok;
  logic [NW-1:0]     rd_idx;
  logic              mem_we;
  logic [NW-1:0]     mem_wa;
  logic [LEVELS-1:0] mem_wd;

  // Sweep every row to zero after reset, then hand the write port to the user
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == NW'(NODES - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // Select the write source
  always_comb begin
    mem_we = busy_r | wr_en;
    mem_wa = busy_r ? clr_cnt_r : NW'(wr_node);
    mem_wd = busy_r ? '0 : wr_data;
  end

  // Absent or out-of-range nodes read as depth zero
  assign rd_ok  = node_ok(rd_node, NODES);
  assign rd_idx = rd_ok ? NW'(rd_node) : '0;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q_r  <= mem[rd_idx];
    rd_ok_r <= rd_ok;
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;
  assign busy    = busy_r;

  a_no_write_during_clear: assert property (
    @(posedge clk) disable iff (!rst_n) busy_r |-> !wr_en
  ) else $error("depth write issued during clearing pass");

endmodule

`default_nettype wire

// File: hdl/lcabl_jump_store.sv
`default_nettype none

module lcabl_jump_store
  import lcabl_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire node_t                      wr_node,
  input  wire logic [$clog2(LEVELS)-1:0]  wr_lvl,
  input  wire node_t                      wr_data,
  input  wire node_t                      ra_node,
  input  wire logic [$clog2(LEVELS)-1:0]  ra_lvl,
  output      node_t                      ra_data,
  input  wire node_t                      rb_node,
  input  wire logic [$clog2(LEVELS)-1:0]  rb_lvl,
  output      node_t                      rb_data
);

  localparam int NW = $clog2(NODES);
  localparam int LW = $clog2(LEVELS);
  localparam int AW = NW + LW;

  node_t         mem [2**AW];
  logic [AW-1:0] wa;
  logic [AW-1:0] ia, ib;
  logic          oka, okb;
  node_t         qa_r, qb_r;
  logic          oka_r, okb_r;
  logic          hita_r, hitb_r;
  node_t         wd_r;

  // Row of a node holds its ancestors, one word per level
  assign wa  = {NW'(wr_node), wr_lvl};
  assign oka = node_ok(ra_node, NODES);
  assign okb = node_ok(rb_node, NODES);
  assign ia  = oka ? {NW'(ra_node), ra_lvl} : '0;
  assign ib  = okb ? {NW'(rb_node), rb_lvl} : '0;

  // Write, read both ports, and note same-cycle collisions for bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wa] <= wr_data;
    end
    qa_r   <= mem[ia];
    qb_r   <= mem[ib];
    oka_r  <= oka;
    okb_r  <= okb;
    hita_r <= wr_en && (ia == wa);
    hitb_r <= wr_en && (ib == wa);
    wd_r   <= wr_data;
  end

  // Node zero and out-of-range nodes have no ancestors
  always_comb begin
    ra_data = '0;
    rb_data = '0;
    if (oka_r) begin
      ra_data = hita_r ? wd_r : qa_r;
    end
    if (okb_r) begin
      rb_data = hitb_r ? wd_r : qb_r;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lcabl_seq.sv
`default_nettype none

module lcabl_seq
  import lcabl_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_stall,
  input  wire in_item_t                  in_data,
  output      logic                      out_valid,
  input  wire logic                      out_stall,
  output      out_item_t                 out_data,
  output      node_t                     d_rd_node,
  input  wire logic [LEVELS-1:0]         d_rd_data,
  output      logic                      d_wr_en,
  output      node_t                     d_wr_node,
  output      logic [LEVELS-1:0]         d_wr_data,
  input  wire logic                      d_busy,
  output      logic                      j_wr_en,
  output      node_t                     j_wr_node,
  output      logic [$clog2(LEVELS)-1:0] j_wr_lvl,
  output      node_t                     j_wr_data,
  output      node_t                     j_ra_node,
  output      logic [$clog2(LEVELS)-1:0] j_ra_lvl,
  input  wire node_t                     j_ra_data,
  output      node_t                     j_rb_node,
  output      logic [$clog2(LEVELS)-1:0] j_rb_lvl,
  input  wire node_t                     j_rb_data
);

  localparam int LW        = $clog2(LEVELS);
  localparam int DW        = LEVELS;
  localparam int MAX_DEPTH = (NODES - 1 < (2**LEVELS) - 1) ? NODES - 1 : (2**LEVELS) - 1;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_START    = 12'b0000_0000_0010,
    S_INS_PD   = 12'b0000_0000_0100,
    S_INS_ROW0 = 12'b0000_0000_1000,
    S_INS_LVL  = 12'b0000_0001_0000,
    S_Q_DA     = 12'b0000_0010_0000,
    S_Q_DB     = 12'b0000_0100_0000,
    S_Q_LIFT   = 12'b0000_1000_0000,
    S_Q_CMP    = 12'b0001_0000_0000,
    S_Q_DOWN   = 12'b0010_0000_0000,
    S_Q_FIN    = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t    state_r, state_nxt;
  func_t     func_r, func_nxt;
  node_t     a_r, a_nxt;
  node_t     b_r, b_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [DW-1:0] diff_r, diff_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic      pend_r, pend_nxt;
  node_t     res_anc_r, res_anc_nxt;
  status_t   res_st_r, res_st_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  always_comb begin
    node_t         cur_a;
    node_t         ca;
    node_t         cb;
    node_t         jval;
    logic [DW-1:0] db;

    state_nxt     = state_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    d_nxt         = d_r;
    diff_nxt      = diff_r;
    lvl_nxt       = lvl_r;
    pend_nxt      = pend_r;
    res_anc_nxt   = res_anc_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    in_stall  = 1'b1;
    d_rd_node = a_r;
    d_wr_en   = 1'b0;
    d_wr_node = a_r;
    d_wr_data = d_r;
    j_wr_en   = 1'b0;
    j_wr_node = a_r;
    j_wr_lvl  = lvl_r;
    j_wr_data = '0;
    j_ra_node = a_r;
    j_ra_lvl  = lvl_r;
    j_rb_node = b_r;
    j_rb_lvl  = lvl_r;

    cur_a = pend_r ? j_ra_data : a_r;
    ca    = (j_ra_data != j_rb_data) ? j_ra_data : a_r;
    cb    = (j_ra_data != j_rb_data) ? j_rb_data : b_r;
    jval  = ((d_r >> lvl_r) != '0) ? j_ra_data : '0;
    db    = d_rd_data;

    // Drop the held result once the output side takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_stall = d_busy;
        if (in_valid && !d_busy) begin
          func_nxt  = in_data.func;
          a_nxt     = in_data.node_a;
          b_nxt     = in_data.node_b;
          state_nxt = S_START;
        end
      end

      S_START: begin
        if (func_r == FUNC_INSERT) begin
          if (!node_ok(a_r, NODES)) begin
            res_anc_nxt = '0;
            res_st_nxt  = ST_REFUSED;
            state_nxt   = S_DONE;
          end else if (b_r == '0) begin
            d_nxt     = DW'(1);
            state_nxt = S_INS_ROW0;
          end else begin
            d_rd_node = b_r;
            state_nxt = S_INS_PD;
          end
        end else begin
          d_rd_node = a_r;
          state_nxt = S_Q_DA;
        end
      end

      // Parent must be present and leave room for one more level of depth
      S_INS_PD: begin
        if (d_rd_data == '0 || d_rd_data >= DW'(MAX_DEPTH)) begin
          res_anc_nxt = '0;
          res_st_nxt  = ST_REFUSED;
          state_nxt   = S_DONE;
        end else begin
          d_nxt     = d_rd_data + 1'b1;
          state_nxt = S_INS_ROW0;
        end
      end

      // Write depth and the direct parent, fetch the parent's first jump
      S_INS_ROW0: begin
        d_wr_en   = 1'b1;
        j_wr_en   = 1'b1;
        j_wr_lvl  = '0;
        j_wr_data = b_r;
        j_ra_node = b_r;
        j_ra_lvl  = '0;
        lvl_nxt   = LW'(1);
        state_nxt = S_INS_LVL;
      end

      // One level per cycle: store the fetched ancestor and chase it
      S_INS_LVL: begin
        j_wr_en   = 1'b1;
        j_wr_data = jval;
        j_ra_node = jval;
        if (lvl_r == LVL_TOP) begin
          res_anc_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end

      S_Q_DA: begin
        d_nxt     = d_rd_data;
        d_rd_node = b_r;
        state_nxt = S_Q_DB;
      end

      // Report an absent node, else order the pair so the deeper node is lifted
      S_Q_DB: begin
        lvl_nxt  = '0;
        pend_nxt = 1'b0;
        if (d_r == '0 || db == '0) begin
          res_anc_nxt = '0;
          res_st_nxt  = ST_ABSENT;
          state_nxt   = S_DONE;
        end else if (d_r < db) begin
          a_nxt     = b_r;
          b_nxt     = a_r;
          diff_nxt  = db - d_r;
          state_nxt = S_Q_LIFT;
        end else begin
          diff_nxt  = d_r - db;
          state_nxt = S_Q_LIFT;
        end
      end

      // Lift by each set bit of the depth difference
      S_Q_LIFT: begin
        a_nxt     = cur_a;
        j_ra_node = cur_a;
        pend_nxt  = diff_r[lvl_r];
        if (lvl_r == LVL_TOP) begin
          state_nxt = S_Q_CMP;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end

      S_Q_CMP: begin
        a_nxt = cur_a;
        if (cur_a == b_r) begin
          res_anc_nxt = cur_a;
          res_st_nxt  = ST_OK;
          state_nxt   = S_DONE;
        end else begin
          j_ra_node = cur_a;
          j_ra_lvl  = LVL_TOP;
          j_rb_lvl  = LVL_TOP;
          lvl_nxt   = LVL_TOP;
          state_nxt = S_Q_DOWN;
        end
      end

      // Move both nodes up wherever their ancestors still differ
      S_Q_DOWN: begin
        a_nxt     = ca;
        b_nxt     = cb;
        j_ra_node = ca;
        j_rb_node = cb;
        if (lvl_r == '0) begin
          j_ra_lvl  = '0;
          state_nxt = S_Q_FIN;
        end else begin
          j_ra_lvl = lvl_r - 1'b1;
          j_rb_lvl = lvl_r - 1'b1;
          lvl_nxt  = lvl_r - 1'b1;
        end
      end

      S_Q_FIN: begin
        res_anc_nxt = j_ra_data;
        res_st_nxt  = ST_OK;
        state_nxt   = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.ancestor = res_anc_r;
          out_data_nxt.status   = res_st_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lvl_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    d_r        <= d_nxt;
    diff_r     <= diff_nxt;
    res_anc_r  <= res_anc_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_insert_no_ancestor: assert property (
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_DONE && func_r == FUNC_INSERT) |-> (res_anc_r == '0)
  ) else $error("insert result carries a nonzero ancestor");

  a_jump_write_on_insert: assert property (
    @(posedge clk) disable iff (!rst_n) j_wr_en |-> (func_r == FUNC_INSERT)
  ) else $error("ancestor table written during a query");

  a_level_in_range: assert property (
    @(posedge clk) disable iff (!rst_n) lvl_r <= LVL_TOP
  ) else $error("level counter beyond top level");

endmodule

`default_nettype wire

// File: hdl/lca_binary_lifting_unit.sv
`default_nettype none

// Lowest common ancestor unit. An insert transfer names a node and its parent
// (parent 0 starts a new tree) and writes the node's depth plus its ancestor at
// every power-of-two distance; a query transfer names two nodes and returns
// their lowest common ancestor, 0 when they lie in different trees. Every item
// gives one result: status 0 ok, 1 query of an absent node, 2 insert refused
// (node 0, absent parent, or the depth limit reached). Parents must be
// inserted before their children. One item is worked at a time, paced by
// chained reads of the ancestor memory (one level per cycle). The next item
// is taken while a finished result waits in the output register. After reset
// the depth memory is cleared one row per cycle, holding in_stall high until
// the clearing pass is done.
module lca_binary_lifting_unit
  import lcabl_pkg::*;
#(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  localparam int LW = $clog2(LEVELS);

  node_t             d_rd_node;
  logic [LEVELS-1:0] d_rd_data;
  logic              d_wr_en;
  node_t             d_wr_node;
  logic [LEVELS-1:0] d_wr_data;
  logic              d_busy;
  logic              j_wr_en;
  node_t             j_wr_node;
  logic [LW-1:0]     j_wr_lvl;
  node_t             j_wr_data;
  node_t             j_ra_node;
  logic [LW-1:0]     j_ra_lvl;
  node_t             j_ra_data;
  node_t             j_rb_node;
  logic [LW-1:0]     j_rb_lvl;
  node_t             j_rb_data;

  lcabl_depth_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_depth (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_node (d_rd_node),
    .rd_data (d_rd_data),
    .wr_en   (d_wr_en),
    .wr_node (d_wr_node),
    .wr_data (d_wr_data),
    .busy    (d_busy)
  );

  lcabl_jump_store #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_jump (
    .clk     (clk),
    .wr_en   (j_wr_en),
    .wr_node (j_wr_node),
    .wr_lvl  (j_wr_lvl),
    .wr_data (j_wr_data),
    .ra_node (j_ra_node),
    .ra_lvl  (j_ra_lvl),
    .ra_data (j_ra_data),
    .rb_node (j_rb_node),
    .rb_lvl  (j_rb_lvl),
    .rb_data (j_rb_data)
  );

  lcabl_seq #(
    .NODES  (NODES),
    .LEVELS (LEVELS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .d_rd_node (d_rd_node),
    .d_rd_data (d_rd_data),
    .d_wr_en   (d_wr_en),
    .d_wr_node (d_wr_node),
    .d_wr_data (d_wr_data),
    .d_busy    (d_busy),
    .j_wr_en   (j_wr_en),
    .j_wr_node (j_wr_node),
    .j_wr_lvl  (j_wr_lvl),
    .j_wr_data (j_wr_data),
    .j_ra_node (j_ra_node),
    .j_ra_lvl  (j_ra_lvl),
    .j_ra_data (j_ra_data),
    .j_rb_node (j_rb_node),
    .j_rb_lvl  (j_rb_lvl),
    .j_rb_data (j_rb_data)
  );

endmodule

`default_nettype wire
